// File: hdl/spsn_pkg.sv
// Package for the serial port state notifier.
// Holds the telnet codes, the item kind codes and the frame job type.
// Has no dependencies; every other file of the block but spsn_if uses it.
`default_nettype none

package spsn_pkg;

  localparam logic [7:0] OPTION_CODE = 8'd44;

  localparam logic [7:0] TEL_IAC = 8'd255;
  localparam logic [7:0] TEL_SB  = 8'd250;
  localparam logic [7:0] TEL_SE  = 8'd240;

  localparam logic [7:0] CODE_LINE_NOTIFY  = 8'd106;
  localparam logic [7:0] CODE_MODEM_NOTIFY = 8'd107;
  localparam logic [7:0] CODE_LINE_MASK    = 8'd110;
  localparam logic [7:0] CODE_MODEM_MASK   = 8'd111;

  localparam logic [1:0] KIND_POLL      = 2'd0;
  localparam logic [1:0] KIND_SET_LINE  = 2'd1;
  localparam logic [1:0] KIND_SET_MODEM = 2'd2;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // One or two frames (a mask echo or notify frames) caused by one transaction.
  typedef struct packed {
    logic       two;
    logic [7:0] code0;
    logic [7:0] data0;
    logic [7:0] code1;
    logic [7:0] data1;
  } job_t;

endpackage

`default_nettype wire

// File: hdl/spsn_if.sv
// Channel interfaces of the serial port state notifier.
// Depends on nothing; used by the top level and the testbench.
`default_nettype none

interface spsn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] mask_value;
  logic       carrier_detect;
  logic       ring_indicator;
  logic       data_set_ready;
  logic       clear_to_send;
  logic       overrun_seen;
  logic       parity_seen;
  logic       framing_seen;
  logic       break_seen;

  modport source (
    output valid, kind, mask_value, carrier_detect, ring_indicator,
           data_set_ready, clear_to_send, overrun_seen, parity_seen,
           framing_seen, break_seen,
    input  ready
  );
  modport sink (
    input  valid, kind, mask_value, carrier_detect, ring_indicator,
           data_set_ready, clear_to_send, overrun_seen, parity_seen,
           framing_seen, break_seen,
    output ready
  );
endinterface

interface spsn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/spsn_front.sv
// Front end: accepts transactions, keeps the notifier state and builds frame jobs.
// Depends on spsn_pkg.
`default_nettype none

module spsn_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [7:0]        mask_value_i,
  input  wire logic [3:0]        levels_i,
  input  wire logic [3:0]        errors_i,
  output logic                   push_o,
  input  wire logic              push_ready_i,
  output spsn_pkg::job_t         job_o
);

  logic [7:0] modem_prev_q, modem_prev_d;
  logic [7:0] line_prev_q, line_prev_d;
  logic [7:0] line_mask_q, line_mask_d;
  logic [7:0] modem_mask_q, modem_mask_d;
  logic       line_ref_q, line_ref_d;
  logic       modem_ref_q, modem_ref_d;
  logic [3:0] pend_q, pend_d;

  logic       accept;
  logic [3:0] pend;
  logic [7:0] ms, ms_m, ls, ls_m;
  logic       send_modem, send_line, send_mask;
  logic [7:0] mask_code;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pend       = pend_q | errors_i;

  always_comb begin
    ms   = {levels_i, levels_i ^ modem_prev_q[7:4]};
    ms_m = ms & modem_mask_q;
    ls   = {3'b000, pend, 1'b0};
    ls_m = ls & line_mask_q;

    modem_prev_d = modem_prev_q;
    line_prev_d  = line_prev_q;
    line_mask_d  = line_mask_q;
    modem_mask_d = modem_mask_q;
    line_ref_d   = line_ref_q;
    modem_ref_d  = modem_ref_q;
    pend_d       = pend;
    send_modem   = 1'b0;
    send_line    = 1'b0;
    send_mask    = 1'b0;
    mask_code    = spsn_pkg::CODE_LINE_MASK;

    unique case (kind_i)
      spsn_pkg::KIND_POLL: begin
        if (modem_mask_q != 8'h00) begin
          modem_prev_d = ms;
          if ((ms[3:0] != 4'h0 || modem_ref_q) && (ms_m != 8'h00 || modem_ref_q)) begin
            send_modem  = 1'b1;
            modem_ref_d = 1'b0;
          end
        end
        if (line_mask_q != 8'h00) begin
          pend_d      = 4'h0;
          line_prev_d = ls;
          if ((ls != line_prev_q || line_ref_q) && (ls_m != 8'h00 || line_ref_q)) begin
            send_line  = 1'b1;
            line_ref_d = 1'b0;
          end
        end
      end
      spsn_pkg::KIND_SET_LINE: begin
        if (line_mask_q != mask_value_i) begin
          line_ref_d = 1'b1;
        end
        line_mask_d = mask_value_i;
        send_mask   = 1'b1;
        mask_code   = spsn_pkg::CODE_LINE_MASK;
      end
      spsn_pkg::KIND_SET_MODEM: begin
        if (modem_mask_q != mask_value_i) begin
          modem_ref_d = 1'b1;
        end
        modem_mask_d = mask_value_i;
        send_mask    = 1'b1;
        mask_code    = spsn_pkg::CODE_MODEM_MASK;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    job_o.two   = send_modem && send_line;
    job_o.code1 = spsn_pkg::CODE_LINE_NOTIFY;
    job_o.data1 = ls_m;
    if (send_mask) begin
      job_o.code0 = mask_code;
      job_o.data0 = mask_value_i;
    end else if (send_modem) begin
      job_o.code0 = spsn_pkg::CODE_MODEM_NOTIFY;
      job_o.data0 = ms_m;
    end else begin
      job_o.code0 = spsn_pkg::CODE_LINE_NOTIFY;
      job_o.data0 = ls_m;
    end
  end

  assign push_o = accept && (send_mask || send_modem || send_line);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modem_prev_q <= 8'h00;
      line_prev_q  <= 8'h00;
      line_mask_q  <= 8'h00;
      modem_mask_q <= 8'hFF;
      line_ref_q   <= 1'b0;
      modem_ref_q  <= 1'b1;
      pend_q       <= 4'h0;
    end else if (accept) begin
      modem_prev_q <= modem_prev_d;
      line_prev_q  <= line_prev_d;
      line_mask_q  <= line_mask_d;
      modem_mask_q <= modem_mask_d;
      line_ref_q   <= line_ref_d;
      modem_ref_q  <= modem_ref_d;
      pend_q       <= pend_d;
    end
  end

  // A mask request always produces an echo frame.
  a_mask_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == spsn_pkg::KIND_SET_LINE || kind_i == spsn_pkg::KIND_SET_MODEM))
    |-> (push_o && !job_o.two))
    else $error("mask request without echo frame");

endmodule

`default_nettype wire

// File: hdl/spsn_fifo.sv
// Short job queue between the front and back ends, held in flip-flops.
// Depends on spsn_pkg.
`default_nettype none

module spsn_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                push_ready_o,
  input  wire spsn_pkg::job_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_i,
  output spsn_pkg::job_t      pop_data_o
);

  localparam logic [spsn_pkg::FIFO_AW:0] FULL_COUNT =
    (spsn_pkg::FIFO_AW + 1)'(spsn_pkg::FIFO_DEPTH);

  spsn_pkg::job_t                 mem_q [spsn_pkg::FIFO_DEPTH];
  logic [spsn_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [spsn_pkg::FIFO_AW:0]     count_q, count_d;
  logic                           do_push, do_pop;

  assign push_ready_o = count_q != FULL_COUNT;
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    priority if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  a_count_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != FULL_COUNT && count_q != '0)
    |-> (wr_ptr_q - rd_ptr_q) == count_q[spsn_pkg::FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: hdl/spsn_back.sv
// Back end: takes frame jobs from the queue and sends them byte by byte.
// Depends on spsn_pkg.
`default_nettype none

module spsn_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  output logic                pop_o,
  input  wire spsn_pkg::job_t job_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o
);

  localparam logic [2:0] SLOT_IAC0 = 3'd0;
  localparam logic [2:0] SLOT_SB   = 3'd1;
  localparam logic [2:0] SLOT_OPT  = 3'd2;
  localparam logic [2:0] SLOT_CODE = 3'd3;
  localparam logic [2:0] SLOT_DUP  = 3'd4;
  localparam logic [2:0] SLOT_DATA = 3'd5;
  localparam logic [2:0] SLOT_IAC1 = 3'd6;
  localparam logic [2:0] SLOT_SE   = 3'd7;

  spsn_pkg::job_t job_q;
  logic           cur_valid_q;
  logic           frm_q;
  logic [2:0]     pos_q;
  logic           out_valid_q;
  logic [7:0]     byte_q;
  logic           last_q;

  logic           advance, frame_end, job_end;
  logic [7:0]     code, data, byte_d;

  assign advance   = cur_valid_q && (!out_valid_q || out_ready_i);
  assign frame_end = pos_q == SLOT_SE;
  assign job_end   = frame_end && (frm_q || !job_q.two);
  assign pop_o     = job_valid_i && (!cur_valid_q || (advance && job_end));
  assign code      = frm_q ? job_q.code1 : job_q.code0;
  assign data      = frm_q ? job_q.data1 : job_q.data0;

  always_comb begin
    unique case (pos_q)
      SLOT_IAC0: byte_d = spsn_pkg::TEL_IAC;
      SLOT_SB:   byte_d = spsn_pkg::TEL_SB;
      SLOT_OPT:  byte_d = spsn_pkg::OPTION_CODE;
      SLOT_CODE: byte_d = code;
      SLOT_DUP:  byte_d = spsn_pkg::TEL_IAC;
      SLOT_DATA: byte_d = data;
      SLOT_IAC1: byte_d = spsn_pkg::TEL_IAC;
      SLOT_SE:   byte_d = spsn_pkg::TEL_SE;
      default:   byte_d = spsn_pkg::TEL_SE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (advance) begin
      byte_q <= byte_d;
      last_q <= job_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      frm_q       <= 1'b0;
      pos_q       <= SLOT_IAC0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        frm_q       <= 1'b0;
        pos_q       <= SLOT_IAC0;
      end else if (advance) begin
        if (job_end) begin
          cur_valid_q <= 1'b0;
        end else if (frame_end) begin
          frm_q <= 1'b1;
          pos_q <= SLOT_IAC0;
        end else if (pos_q == SLOT_CODE && data != spsn_pkg::TEL_IAC) begin
          pos_q <= SLOT_DATA;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;

  a_last_is_se: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> byte_q == spsn_pkg::TEL_SE)
    else $error("final byte of a transaction is not SE");

  a_dup_only_iac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && pos_q == SLOT_DUP) |-> data == spsn_pkg::TEL_IAC)
    else $error("IAC doubled for a data byte other than IAC");

endmodule

`default_nettype wire

// File: hdl/serial_port_state_notifier_top.sv
// Top level of the serial port state notifier: front end, job queue, back end.
// Depends on spsn_pkg, spsn_if, spsn_front, spsn_fifo and spsn_back.
//
//   Port    Dir  Role     Payload
//   in_i    in   sink     kind, mask_value, four modem levels, four error pulses
//   out_o   out  source   out_byte, last_byte
//
// The front end accepts one transaction per cycle while the four-entry job queue has room.
// The back end sends one byte per cycle while the output is not stalled: 7 or 8 bytes per frame, up to 16 for a poll.
// Reset sets the notifier state to its start values and empties the queue; no clearing pass follows.
// A stalled output holds the back end only; the front end runs until the queue fills.
`default_nettype none

module serial_port_state_notifier_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spsn_in_if.sink     in_i,
  spsn_out_if.source  out_o
);

  logic           push, push_ready, pop, pop_valid;
  spsn_pkg::job_t push_job, pop_job;

  spsn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .kind_i       (in_i.kind),
    .mask_value_i (in_i.mask_value),
    .levels_i     ({in_i.carrier_detect, in_i.ring_indicator,
                    in_i.data_set_ready, in_i.clear_to_send}),
    .errors_i     ({in_i.break_seen, in_i.framing_seen,
                    in_i.parity_seen, in_i.overrun_seen}),
    .push_o       (push),
    .push_ready_i (push_ready),
    .job_o        (push_job)
  );

  spsn_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_job)
  );

  spsn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .pop_o       (pop),
    .job_i       (pop_job),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .last_byte_o (out_o.last_byte)
  );

endmodule

`default_nettype wire

// File: tb/sv/serial_port_state_notifier_top_tb.sv
`timescale 1ns / 1ps
// Testbench for serial_port_state_notifier_top: directed and random transactions,
// a built-in notifier predictor and a byte-by-byte check of every output frame.
// Depends on spsn_pkg, spsn_if and the RTL of the top level.

module serial_port_state_notifier_top_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mask_value;
    logic [3:0] lines;
    logic [3:0] errors;
  } port_event_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } notify_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spsn_in_if  in_if ();
  spsn_out_if out_if ();

  serial_port_state_notifier_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  notify_byte_t expected_bytes[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_request = 0;
  bit idle_enable = 1'b1;
  logic [3:0] last_lines = 4'b0000;

  logic [7:0] seen_modem_byte = 8'h00;
  logic [7:0] seen_line_byte = 8'h00;
  logic [7:0] line_mask = 8'h00;
  logic [7:0] modem_mask = 8'hFF;
  logic       line_resend = 1'b0;
  logic       modem_resend = 1'b1;
  logic [3:0] held_errors = 4'h0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void push_frame(input logic [7:0] code, input logic [7:0] data);
    expected_bytes.push_back('{spsn_pkg::TEL_IAC, 1'b0});
    expected_bytes.push_back('{spsn_pkg::TEL_SB, 1'b0});
    expected_bytes.push_back('{spsn_pkg::OPTION_CODE, 1'b0});
    expected_bytes.push_back('{code, 1'b0});
    if (data == spsn_pkg::TEL_IAC) expected_bytes.push_back('{spsn_pkg::TEL_IAC, 1'b0});
    expected_bytes.push_back('{data, 1'b0});
    expected_bytes.push_back('{spsn_pkg::TEL_IAC, 1'b0});
    expected_bytes.push_back('{spsn_pkg::TEL_SE, 1'b0});
  endfunction

  function automatic void predict_notify(input port_event_t ev);
    int before_size;
    logic [7:0] levels;
    logic [7:0] state_byte;
    logic [7:0] line_delta;
    before_size = expected_bytes.size();
    held_errors = held_errors | ev.errors;
    case (ev.kind)
      spsn_pkg::KIND_POLL: begin
        if (modem_mask != 8'h00) begin
          levels = {ev.lines, 4'b0000};
          state_byte = levels | ((levels ^ seen_modem_byte) >> 4);
          seen_modem_byte = state_byte;
          if (state_byte[3:0] != 4'h0 || modem_resend) begin
            state_byte = state_byte & modem_mask;
            if (state_byte != 8'h00 || modem_resend) begin
              push_frame(spsn_pkg::CODE_MODEM_NOTIFY, state_byte);
              modem_resend = 1'b0;
            end
          end
        end
        if (line_mask != 8'h00) begin
          state_byte = {3'b000, held_errors, 1'b0};
          line_delta = state_byte ^ seen_line_byte;
          held_errors = 4'h0;
          seen_line_byte = state_byte;
          if (line_delta != 8'h00 || line_resend) begin
            state_byte = state_byte & line_mask;
            if (state_byte != 8'h00 || line_resend) begin
              push_frame(spsn_pkg::CODE_LINE_NOTIFY, state_byte);
              line_resend = 1'b0;
            end
          end
        end
      end
      spsn_pkg::KIND_SET_LINE: begin
        if (line_mask != ev.mask_value) line_resend = 1'b1;
        line_mask = ev.mask_value;
        push_frame(spsn_pkg::CODE_LINE_MASK, ev.mask_value);
      end
      spsn_pkg::KIND_SET_MODEM: begin
        if (modem_mask != ev.mask_value) modem_resend = 1'b1;
        modem_mask = ev.mask_value;
        push_frame(spsn_pkg::CODE_MODEM_MASK, ev.mask_value);
      end
      default: begin
      end
    endcase
    if (expected_bytes.size() > before_size) begin
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic port_event_t make_event(input logic [1:0] kind, input logic [7:0] mask_value,
                                             input logic [3:0] lines, input logic [3:0] errors);
    port_event_t ev;
    ev.kind = kind;
    ev.mask_value = mask_value;
    ev.lines = lines;
    ev.errors = errors;
    return ev;
  endfunction

  function automatic port_event_t random_event();
    port_event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) ev.kind = spsn_pkg::KIND_POLL;
    else if (pick < 80) ev.kind = spsn_pkg::KIND_SET_LINE;
    else if (pick < 96) ev.kind = spsn_pkg::KIND_SET_MODEM;
    else ev.kind = KIND_UNUSED;
    case ($urandom_range(0, 3))
      0: ev.mask_value = 8'h00;
      1: ev.mask_value = 8'hFF;
      default: ev.mask_value = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 1) == 1) last_lines = 4'($urandom_range(0, 15));
    ev.lines = last_lines;
    ev.errors = {$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                 $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0};
    return ev;
  endfunction

  task automatic send_event(input port_event_t ev);
    int gap;
    gap = idle_enable ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.kind           <= ev.kind;
    in_if.mask_value     <= ev.mask_value;
    in_if.carrier_detect <= ev.lines[3];
    in_if.ring_indicator <= ev.lines[2];
    in_if.data_set_ready <= ev.lines[1];
    in_if.clear_to_send  <= ev.lines[0];
    in_if.overrun_seen   <= ev.errors[0];
    in_if.parity_seen    <= ev.errors[1];
    in_if.framing_seen   <= ev.errors[2];
    in_if.break_seen     <= ev.errors[3];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_notify(ev);
  endtask

  task automatic wait_until_drained();
    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_refresh_after_reset();
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h5A, 4'b1010, 4'b0000));
    wait_until_drained();
  endtask

  task automatic test_modem_deltas();
    send_event(make_event(spsn_pkg::KIND_POLL, 8'hFF, 4'b0000, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b1111, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b1111, 4'b0000));
    wait_until_drained();
  endtask

  task automatic test_mask_requests();
    send_event(make_event(spsn_pkg::KIND_SET_MODEM, 8'h00, 4'b1111, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b0101, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_SET_MODEM, 8'hFF, 4'b0000, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'hC3, 4'b0101, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_SET_LINE, 8'hFF, 4'b1111, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_SET_LINE, 8'hFF, 4'b0000, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_SET_LINE, 8'h00, 4'b0000, 4'b0000));
    send_event(make_event(KIND_UNUSED, 8'hFF, 4'b1111, 4'b0000));
    wait_until_drained();
  endtask

  task automatic test_line_errors();
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b0101, 4'b1111));
    send_event(make_event(spsn_pkg::KIND_SET_LINE, 8'h1E, 4'b0000, 4'b0001));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b0101, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b0101, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b0101, 4'b0100));
    send_event(make_event(spsn_pkg::KIND_SET_LINE, 8'h02, 4'b0101, 4'b0000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b0101, 4'b1110));
    send_event(make_event(KIND_UNUSED, 8'h00, 4'b0101, 4'b1000));
    send_event(make_event(spsn_pkg::KIND_POLL, 8'h00, 4'b0101, 4'b0000));
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    idle_enable = with_idle;
    repeat (count) send_event(random_event());
    wait_until_drained();
    idle_enable = 1'b1;
  endtask

  task automatic test_output_backpressure();
    port_event_t ev;
    idle_enable = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 12; i++) begin
      ev = random_event();
      ev.kind = (i % 2 == 0) ? spsn_pkg::KIND_SET_LINE : spsn_pkg::KIND_SET_MODEM;
      send_event(ev);
    end
    wait_until_drained();
    idle_enable = 1'b1;
  endtask

  initial begin : out_ready_drive
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (out_if.valid && out_if.ready) begin
        stall_left = idle_enable ? $urandom_range(0, 17) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_notify_bytes
    notify_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected out_byte", out_if.out_byte, -1);
      end else begin
        want = expected_bytes.pop_front();
        if (out_if.out_byte !== want.data) begin
          report_mismatch("out_byte", out_if.out_byte, want.data);
        end
        if (out_if.last_byte !== want.last) begin
          report_mismatch("last_byte", out_if.last_byte, want.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[serial_port_state_notifier_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.kind           <= spsn_pkg::KIND_POLL;
    in_if.mask_value     <= 8'h00;
    in_if.carrier_detect <= 1'b0;
    in_if.ring_indicator <= 1'b0;
    in_if.data_set_ready <= 1'b0;
    in_if.clear_to_send  <= 1'b0;
    in_if.overrun_seen   <= 1'b0;
    in_if.parity_seen    <= 1'b0;
    in_if.framing_seen   <= 1'b0;
    in_if.break_seen     <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_refresh_after_reset();
    test_modem_deltas();
    test_mask_requests();
    test_line_errors();
    test_random_traffic(25, 1'b0);
    test_output_backpressure();
    test_random_traffic(52, 1'b1);

    if (expected_bytes.size() != 0) begin
      report_mismatch("bytes never sent", 0, expected_bytes.size());
    end
    if (mismatch_count == 0) begin
      $display("[serial_port_state_notifier_top] OK");
    end else begin
      $display("[serial_port_state_notifier_top] ERROR");
    end
    $finish;
  end

endmodule
